/* hdl/bhwp_pkg.sv */
// bhwp_pkg: shared types, constants and helper functions for the bone world pose block
// no dependencies; imported by bhwp_front, bhwp_fifo, bhwp_back and the top level
package bhwp_pkg;

   // rotation units: 1/64 degree, full turn, half turn and quarter turn
   localparam logic [24:0] ROT_FULL_U = 25'd23040;
   localparam logic signed [15:0] ROT_FULL_S = 16'sd23040;
   localparam logic signed [15:0] ROT_HALF_S = 16'sd11520;
   localparam logic signed [15:0] ROT_QUARTER_S = 16'sd5760;
   // multiple of a full turn that makes any 24-bit rotation non-negative
   localparam logic [24:0] ROT_BIAS = 25'd8409600;
   localparam logic [3:0] RED_TOP = 4'd9;
   // radians per unit and cordic start value, both q2.30
   localparam logic signed [20:0] RAD_PER_UNIT = 21'sd292818;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   // number of products per bone on the shared multiplier
   localparam logic [4:0] MUL_OPS = 5'd16;
   localparam logic [3:0] OP_LOCAL_LAST = 4'd3;
   localparam logic [3:0] OP_POS_X = 4'd4;
   localparam logic [3:0] OP_POS_Y = 4'd6;
   localparam logic [3:0] OP_LAST = 4'd15;

   // one classified request between front and back
   typedef struct packed {
      logic [5:0] bone_id;
      logic [6:0] parent_id;
      logic bad_parent;
      logic use_parent;
      logic signed [31:0] local_x;
      logic signed [31:0] local_y;
      logic signed [23:0] scale_x;
      logic signed [23:0] scale_y;
      logic signed [33:0] angle;
      logic negate;
   } bhwp_item_type;

   // arctangent of 2^-i, q2.30, truncated
   function automatic logic [29:0] atan_lut(input logic [4:0] i);
      logic [29:0] r;
      begin
         case (i)
            5'd0: r = 30'h3243F6A8;
            5'd1: r = 30'h1DAC6705;
            5'd2: r = 30'h0FADBAFC;
            5'd3: r = 30'h07F56EA6;
            5'd4: r = 30'h03FEAB76;
            5'd5: r = 30'h01FFD55B;
            5'd6: r = 30'h00FFFAAA;
            5'd7: r = 30'h007FFF55;
            5'd8: r = 30'h003FFFEA;
            5'd9: r = 30'h001FFFFD;
            5'd10: r = 30'h000FFFFF;
            5'd11: r = 30'h0007FFFF;
            5'd12: r = 30'h0003FFFF;
            5'd13: r = 30'h0001FFFF;
            5'd14: r = 30'h0000FFFF;
            5'd15: r = 30'h00007FFF;
            5'd16: r = 30'h00003FFF;
            5'd17: r = 30'h00001FFF;
            5'd18: r = 30'h00000FFF;
            5'd19: r = 30'h000007FF;
            5'd20: r = 30'h000003FF;
            5'd21: r = 30'h000001FF;
            5'd22: r = 30'h000000FF;
            5'd23: r = 30'h0000007F;
            default: r = 30'h0;
         endcase
         return r;
      end
   endfunction

   // saturate a wide sum to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      begin
         if (v > 66'sd2147483647) r = 32'sh7FFFFFFF;
         else if (v < -66'sd2147483648) r = 32'sh80000000;
         else r = v[31:0];
         return r;
      end
   endfunction

endpackage

/* hdl/bhwp_front.sv */
// bhwp_front: accepts requests, flags bad parents, reduces the rotation to an angle
// depends on bhwp_pkg; feeds bhwp_fifo
module bhwp_front #(
   parameter int MAX_BONES = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [5:0] bone_id,
   input  logic [6:0] parent_id,
   input  logic signed [31:0] local_x,
   input  logic signed [31:0] local_y,
   input  logic signed [23:0] rotation,
   input  logic signed [23:0] scale_x,
   input  logic signed [23:0] scale_y,
   output logic push,
   output bhwp_pkg::bhwp_item_type push_item,
   input  logic full
);
   import bhwp_pkg::*;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_RED = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [3:0] k_ff, k_in;
   logic [24:0] v_ff, v_in;
   bhwp_item_type item_ff, item_in;
   logic [24:0] step_val;
   logic signed [15:0] m0, m1, m2;
   logic fold_neg;
   logic signed [36:0] ang_prod;
   logic [10:0] par_w, idx_w;
   logic par_bad;

   assign req_tready = (state_ff == F_IDLE);

   // parent check against this bone and the store depth
   assign par_w = {4'd0, parent_id};
   assign idx_w = {5'd0, bone_id};
   assign par_bad = !parent_id[6] && ((par_w >= idx_w) || (par_w >= 11'(MAX_BONES)));

   // restoring reduction step and final fold into [-90,90] degrees
   assign step_val = ROT_FULL_U << k_ff;
   always_comb begin
      m0 = 16'(v_ff);
      m1 = (m0 >= ROT_HALF_S) ? (m0 - ROT_FULL_S) : m0;
      fold_neg = 1'b0;
      m2 = m1;
      if (m1 > ROT_QUARTER_S) begin
         m2 = m1 - ROT_HALF_S;
         fold_neg = 1'b1;
      end else if (m1 < -ROT_QUARTER_S) begin
         m2 = m1 + ROT_HALF_S;
         fold_neg = 1'b1;
      end
      ang_prod = 37'(m2) * 37'(RAD_PER_UNIT);
   end

   always_comb begin
      push_item = item_ff;
      push_item.angle = ang_prod[33:0];
      push_item.negate = fold_neg;
   end
   assign push = (state_ff == F_PUSH) && !full;

   // sequencer
   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      v_in = v_ff;
      item_in = item_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_tvalid) begin
               item_in.bone_id = bone_id;
               item_in.parent_id = parent_id;
               item_in.bad_parent = par_bad;
               item_in.use_parent = !parent_id[6] && !par_bad;
               item_in.local_x = local_x;
               item_in.local_y = local_y;
               item_in.scale_x = scale_x;
               item_in.scale_y = scale_y;
               item_in.angle = '0;
               item_in.negate = 1'b0;
               v_in = 25'(rotation) + ROT_BIAS;
               k_in = RED_TOP;
               state_in = F_RED;
            end
         end
         F_RED: begin
            if (v_ff >= step_val) v_in = v_ff - step_val;
            k_in = k_ff - 4'd1;
            if (k_ff == 4'd0) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      k_ff <= k_in;
      v_ff <= v_in;
      item_ff <= item_in;
   end

endmodule

/* hdl/bhwp_fifo.sv */
// bhwp_fifo: two-entry queue of classified requests between front and back
// depends on bhwp_pkg
module bhwp_fifo (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  bhwp_pkg::bhwp_item_type push_item,
   output logic full,
   input  logic pop,
   output logic not_empty,
   output bhwp_pkg::bhwp_item_type pop_item
);
   import bhwp_pkg::*;

   bhwp_item_type slot_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_item = slot_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

endmodule

/* hdl/bhwp_back.sv */
// bhwp_back: cordic, shared multiplier sequence, pose store and response register
// depends on bhwp_pkg; takes requests from bhwp_fifo
module bhwp_back #(
   parameter int MAX_BONES = 64,
   parameter int CORDIC_STEPS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic not_empty,
   input  bhwp_pkg::bhwp_item_type pop_item,
   output logic pop,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [191:0] rsp_tdata,
   output logic rsp_tuser
);
   import bhwp_pkg::*;

   localparam int AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_CORD = 3'd1;
   localparam logic [2:0] B_MUL = 3'd2;
   localparam logic [2:0] B_FIN = 3'd3;
   localparam logic [2:0] B_OUT = 3'd4;

   logic [2:0] state_ff, state_in;
   bhwp_item_type item_ff;
   logic [191:0] pose_mem [MAX_BONES];
   logic [191:0] par_q_ff;
   logic signed [33:0] x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic signed [33:0] cs_ff, sn_ff;
   logic [4:0] i_ff;
   logic [4:0] k_ff;
   logic [3:0] kd_ff;
   logic mv_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] op_a, op_b;
   logic signed [31:0] loc_ff [4];
   logic signed [31:0] res_ff [6];
   logic signed [65:0] acc_ff;
   logic signed [63:0] term;
   logic signed [65:0] base;
   logic signed [31:0] pa, pb, pc, pd, px, py;
   logic rsp_tvalid_ff;
   logic [191:0] rsp_tdata_ff;
   logic rsp_tuser_ff;
   logic out_free;
   logic [10:0] idx_w;
   logic [10:0] par_w;

   assign px = par_q_ff[31:0];
   assign py = par_q_ff[63:32];
   assign pa = par_q_ff[95:64];
   assign pb = par_q_ff[127:96];
   assign pc = par_q_ff[159:128];
   assign pd = par_q_ff[191:160];
   assign idx_w = {5'd0, item_ff.bone_id};
   assign par_w = {4'd0, pop_item.parent_id};

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign pop = (state_ff == B_IDLE) && not_empty;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;

   // one cordic rotation step
   always_comb begin
      if (!z_ff[33]) begin
         x_in = x_ff - (y_ff >>> i_ff);
         y_in = y_ff + (x_ff >>> i_ff);
         z_in = z_ff - 34'(atan_lut(i_ff));
      end else begin
         x_in = x_ff + (y_ff >>> i_ff);
         y_in = y_ff - (x_ff >>> i_ff);
         z_in = z_ff + 34'(atan_lut(i_ff));
      end
   end

   // operand selection for the shared multiplier
   always_comb begin
      case (k_ff[3:0])
         4'd0: begin op_a = cs_ff[31:0]; op_b = 32'(item_ff.scale_x); end
         4'd1: begin op_a = -sn_ff[31:0]; op_b = 32'(item_ff.scale_y); end
         4'd2: begin op_a = sn_ff[31:0]; op_b = 32'(item_ff.scale_x); end
         4'd3: begin op_a = cs_ff[31:0]; op_b = 32'(item_ff.scale_y); end
         4'd4: begin op_a = item_ff.local_x; op_b = pa; end
         4'd5: begin op_a = item_ff.local_y; op_b = pb; end
         4'd6: begin op_a = item_ff.local_x; op_b = pc; end
         4'd7: begin op_a = item_ff.local_y; op_b = pd; end
         4'd8: begin op_a = pa; op_b = loc_ff[0]; end
         4'd9: begin op_a = pb; op_b = loc_ff[2]; end
         4'd10: begin op_a = pa; op_b = loc_ff[1]; end
         4'd11: begin op_a = pb; op_b = loc_ff[3]; end
         4'd12: begin op_a = pc; op_b = loc_ff[0]; end
         4'd13: begin op_a = pd; op_b = loc_ff[2]; end
         4'd14: begin op_a = pc; op_b = loc_ff[1]; end
         default: begin op_a = pd; op_b = loc_ff[3]; end
      endcase
   end

   // rounding of the registered product and the running pair sum
   always_comb begin
      if (kd_ff <= OP_LOCAL_LAST) term = (prod_ff + 64'sd536870912) >>> 30;
      else term = (prod_ff + 64'sd32768) >>> 16;
      if (kd_ff == OP_POS_X) base = 66'(px);
      else if (kd_ff == OP_POS_Y) base = 66'(py);
      else base = '0;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (not_empty) state_in = B_CORD;
         B_CORD: if (i_ff == 5'(CORDIC_STEPS - 1)) state_in = B_MUL;
         B_MUL: if (k_ff == MUL_OPS - 5'd1) state_in = B_FIN;
         B_FIN: state_in = B_OUT;
         B_OUT: if (out_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         mv_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mv_ff <= (state_ff == B_MUL);
         if (state_ff == B_OUT && out_free) rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
      end

      // take a request and fetch the parent pose
      if (pop) begin
         item_ff <= pop_item;
         par_q_ff <= pose_mem[par_w[AW-1:0]];
         x_ff <= CORDIC_GAIN;
         y_ff <= '0;
         z_ff <= pop_item.angle;
         i_ff <= '0;
      end

      // cordic iterations, sign of the fold applied at the end
      if (state_ff == B_CORD) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         i_ff <= i_ff + 5'd1;
         k_ff <= '0;
         cs_ff <= item_ff.negate ? -x_in : x_in;
         sn_ff <= item_ff.negate ? -y_in : y_in;
      end

      // issue one product a cycle
      if (state_ff == B_MUL) begin
         prod_ff <= 64'(op_a) * 64'(op_b);
         kd_ff <= k_ff[3:0];
         k_ff <= k_ff + 5'd1;
      end

      // accumulate: local entries first, then pairs of world terms
      if (mv_ff) begin
         if (kd_ff <= OP_LOCAL_LAST) begin
            loc_ff[kd_ff[1:0]] <= term[31:0];
         end else if (!kd_ff[0]) begin
            acc_ff <= base + 66'(term);
         end else begin
            res_ff[3'((kd_ff - OP_POS_X) >> 1)] <= sat32(acc_ff + 66'(term));
         end
      end

      // response register and pose store
      if (state_ff == B_OUT && out_free) begin
         rsp_tuser_ff <= item_ff.bad_parent;
         if (item_ff.use_parent) begin
            rsp_tdata_ff <= {res_ff[5], res_ff[4], res_ff[3], res_ff[2], res_ff[1], res_ff[0]};
         end else begin
            rsp_tdata_ff <= {loc_ff[3], loc_ff[2], loc_ff[1], loc_ff[0],
                             item_ff.local_y, item_ff.local_x};
         end
         if (idx_w < 11'(MAX_BONES)) begin
            if (item_ff.use_parent) begin
               pose_mem[idx_w[AW-1:0]] <= {res_ff[5], res_ff[4], res_ff[3],
                                           res_ff[2], res_ff[1], res_ff[0]};
            end else begin
               pose_mem[idx_w[AW-1:0]] <= {loc_ff[3], loc_ff[2], loc_ff[1], loc_ff[0],
                                           item_ff.local_y, item_ff.local_x};
            end
         end
      end
   end

endmodule

/* hdl/bone_hierarchy_world_pose_top.sv */
// bone_hierarchy_world_pose_top: 2d skeletal forward kinematics, one bone per request
// depends on bhwp_pkg, bhwp_front, bhwp_fifo and bhwp_back
//
// Usage: one request per bone on the req_ stream, bones in index order, each parent
// before its children. Each request returns one response on the rsp_ stream with the
// world position and 2x2 world matrix, q16.16 saturated; tuser flags a bad parent, in
// which case the bone is handled as a root.
// The front reduces the rotation in ten restoring steps, the queue holds the classified
// request, and the back runs the cordic iterations and then the sixteen products that
// go one a cycle through the single shared multiplier.
// The front works on the next request while the back finishes the current one.
// The pose store holds MAX_BONES entries and needs no clearing: a parent that was
// never written is not a legal request.
// Reset clears the queue, both sequencers and the response valid; stored poses stay.
// When the receiver stalls the response holds in its register, the back waits with
// the next finished bone, and the queue and then req_tready back-pressure the source.
module bone_hierarchy_world_pose_top #(
   parameter int MAX_BONES = 64,
   parameter int CORDIC_STEPS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // bone_index[5:0], parent_index[12:6], local_x[44:13], local_y[76:45],
   // rotation[100:77], scale_x[124:101], scale_y[148:125], zero fill
   input  logic [151:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // world_x[31:0], world_y[63:32], mat_a[95:64], mat_b[127:96],
   // mat_c[159:128], mat_d[191:160]
   output logic [191:0] rsp_tdata,
   // bad_parent[0]
   output logic rsp_tuser
);
   import bhwp_pkg::*;

   logic push, full, pop, not_empty;
   bhwp_item_type push_item, pop_item;

   // front: accept and classify
   bhwp_front #(.MAX_BONES(MAX_BONES)) u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .bone_id(req_tdata[5:0]),
      .parent_id(req_tdata[12:6]),
      .local_x(req_tdata[44:13]),
      .local_y(req_tdata[76:45]),
      .rotation(req_tdata[100:77]),
      .scale_x(req_tdata[124:101]),
      .scale_y(req_tdata[148:125]),
      .push(push),
      .push_item(push_item),
      .full(full)
   );

   // queue between the two halves
   bhwp_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_item(push_item),
      .full(full),
      .pop(pop),
      .not_empty(not_empty),
      .pop_item(pop_item)
   );

   // back: trigonometry, composition, store and response
   bhwp_back #(.MAX_BONES(MAX_BONES), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock(clock),
      .reset(reset),
      .not_empty(not_empty),
      .pop_item(pop_item),
      .pop(pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

endmodule

/* hdl/bhwp_checker.sv */
// bhwp_props: port-level checks on the bone world pose block
// depends on bone_hierarchy_world_pose_top; attached by the bind below
module bhwp_props (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [191:0] rsp_tdata,
   input logic rsp_tuser
);

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // the front does not accept a new request straight after taking one
   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken on consecutive cycles");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

endmodule

bind bone_hierarchy_world_pose_top bhwp_props u_bhwp_props (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);

/* dv/bhwp_checker.sv */
// bhwp_checker: watches the request and response streams of the bone world pose block,
// predicts each world pose and compares it field by field; needs only the clock and ports
`timescale 1ns / 1ps

module bhwp_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [151:0] req_tdata,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [191:0] rsp_tdata,
   input  logic rsp_tuser,
   output int fail_count,
   output int poses_pending
);

   localparam int BONES = 64;
   localparam int STEPS = 16;
   localparam longint TURN = 23040;
   localparam longint HALF_TURN = 11520;
   localparam longint QUARTER_TURN = 5760;

   typedef struct {
      logic signed [31:0] wx, wy, ma, mb, mc, md;
      logic bad;
   } world_pose_type;

   // arctangent steps, q2.30
   longint arctan_q30 [24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

   // shadow copy of the pose store
   logic signed [31:0] shadow_x [BONES];
   logic signed [31:0] shadow_y [BONES];
   logic signed [31:0] shadow_a [BONES];
   logic signed [31:0] shadow_b [BONES];
   logic signed [31:0] shadow_c [BONES];
   logic signed [31:0] shadow_d [BONES];

   world_pose_type expected_poses [$];

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // q16.16 product, rounded half up
   function automatic longint qmul(input longint a, input longint b);
      return (a * b + 32768) >>> 16;
   endfunction

   // sine and cosine of a rotation in 1/64 degree, q2.30
   task automatic sin_cos(input longint units, output longint cs, output longint sn);
      longint m, x, y, z, xs, ys;
      logic flip;
      m = ((units % TURN) + TURN) % TURN;
      flip = 1'b0;
      if (m >= HALF_TURN) m -= TURN;
      if (m > QUARTER_TURN) begin
         m -= HALF_TURN;
         flip = 1'b1;
      end else if (m < -QUARTER_TURN) begin
         m += HALF_TURN;
         flip = 1'b1;
      end
      x = 652032874;
      y = 0;
      z = m * 292818;
      for (int i = 0; i < STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys;
            y += xs;
            z -= arctan_q30[i];
         end else begin
            x += ys;
            y -= xs;
            z += arctan_q30[i];
         end
      end
      cs = flip ? -x : x;
      sn = flip ? -y : y;
   endtask

   // world pose of one bone request, updating the shadow store
   task automatic compose_pose(input logic [151:0] d);
      logic [5:0] idx;
      longint par, lx, ly, rot, sx, sy, cs, sn, la, lb, lc, ld, pa, pb, pc, pd;
      world_pose_type w;
      idx = d[5:0];
      par = longint'($signed(d[12:6]));
      lx = longint'($signed(d[44:13]));
      ly = longint'($signed(d[76:45]));
      rot = longint'($signed(d[100:77]));
      sx = longint'($signed(d[124:101]));
      sy = longint'($signed(d[148:125]));
      sin_cos(rot, cs, sn);
      la = (cs * sx + (64'sd1 <<< 29)) >>> 30;
      lb = (-sn * sy + (64'sd1 <<< 29)) >>> 30;
      lc = (sn * sx + (64'sd1 <<< 29)) >>> 30;
      ld = (cs * sy + (64'sd1 <<< 29)) >>> 30;
      w.bad = 1'b0;
      if (par >= 0 && (par >= idx || par >= BONES)) begin
         w.bad = 1'b1;
         par = -1;
      end
      if (par < 0) begin
         w.wx = clamp32(lx);
         w.wy = clamp32(ly);
         w.ma = clamp32(la);
         w.mb = clamp32(lb);
         w.mc = clamp32(lc);
         w.md = clamp32(ld);
      end else begin
         pa = shadow_a[par];
         pb = shadow_b[par];
         pc = shadow_c[par];
         pd = shadow_d[par];
         w.wx = clamp32(longint'(shadow_x[par]) + qmul(lx, pa) + qmul(ly, pb));
         w.wy = clamp32(longint'(shadow_y[par]) + qmul(lx, pc) + qmul(ly, pd));
         w.ma = clamp32(qmul(pa, la) + qmul(pb, lc));
         w.mb = clamp32(qmul(pa, lb) + qmul(pb, ld));
         w.mc = clamp32(qmul(pc, la) + qmul(pd, lc));
         w.md = clamp32(qmul(pc, lb) + qmul(pd, ld));
      end
      shadow_x[idx] = w.wx;
      shadow_y[idx] = w.wy;
      shadow_a[idx] = w.ma;
      shadow_b[idx] = w.mb;
      shadow_c[idx] = w.mc;
      shadow_d[idx] = w.md;
      expected_poses = {expected_poses, w};
   endtask

   task automatic report(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      poses_pending = 0;
   end

   // predict on each accepted request, compare on each accepted response
   always @(posedge clock) begin
      world_pose_type w;
      if (!reset) begin
         if (req_tvalid && req_tready) compose_pose(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_poses.size() == 0) begin
               report("unexpected response", 1, 0);
            end else begin
               w = expected_poses.pop_front();
               if ($signed(rsp_tdata[31:0]) != w.wx)
                  report("world_x", $signed(rsp_tdata[31:0]), w.wx);
               if ($signed(rsp_tdata[63:32]) != w.wy)
                  report("world_y", $signed(rsp_tdata[63:32]), w.wy);
               if ($signed(rsp_tdata[95:64]) != w.ma)
                  report("mat_a", $signed(rsp_tdata[95:64]), w.ma);
               if ($signed(rsp_tdata[127:96]) != w.mb)
                  report("mat_b", $signed(rsp_tdata[127:96]), w.mb);
               if ($signed(rsp_tdata[159:128]) != w.mc)
                  report("mat_c", $signed(rsp_tdata[159:128]), w.mc);
               if ($signed(rsp_tdata[191:160]) != w.md)
                  report("mat_d", $signed(rsp_tdata[191:160]), w.md);
               if (rsp_tuser !== w.bad) report("bad_parent", rsp_tuser, w.bad);
            end
         end
      end
      poses_pending = expected_poses.size();
   end

endmodule

/* dv/testbench.sv */
// testbench: drives skeletons of bone requests into the bone world pose block with random
// gaps and response stalls; depends on bone_hierarchy_world_pose_top and bhwp_checker
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int RANDOM_BONES = 1830;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [151:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [191:0] rsp_tdata;
   logic rsp_tuser;
   int fail_count;
   int poses_pending;
   int cycle_count = 0;
   int resp_hold = 0;
   logic quiet = 1'b0;
   logic written [64];
   int roots = 0, children = 0, bad_links = 0;

   always #5 clock = ~clock;

   bone_hierarchy_world_pose_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   bhwp_checker chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .fail_count(fail_count), .poses_pending(poses_pending)
   );

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // response side stalls a random number of cycles after each response
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_tready <= 1'b0;
         resp_hold <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         n = quiet ? 0 : $urandom_range(0, 13);
         resp_hold <= n;
         rsp_tready <= (n == 0);
      end else if (resp_hold > 0) begin
         resp_hold <= resp_hold - 1;
         rsp_tready <= (resp_hold == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // one bone request; valid stays high straight into the next request when no gap
   task automatic send_bone(input logic [5:0] idx, input logic signed [6:0] par,
                            input logic [31:0] lx, input logic [31:0] ly,
                            input logic [23:0] rot, input logic [23:0] sx,
                            input logic [23:0] sy);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b0, sy, sx, rot, ly, lx, par, idx};
      do @(posedge clock); while (!req_tready);
      written[idx] = 1'b1;
      if (par < 0) roots++;
      else if (par >= $signed({1'b0, idx})) bad_links++;
      else children++;
   endtask

   function automatic logic [31:0] pick_offset();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
         default: return 32'($signed($urandom_range(0, 40000000)) - 20000000);
      endcase
   endfunction

   function automatic logic [23:0] pick_scale();
      case ($urandom_range(0, 3))
         0: return 24'($urandom());
         1: return 24'($signed($urandom_range(0, 262144)) - 131072);
         default: return 24'($urandom_range(32768, 98304));
      endcase
   endfunction

   function automatic logic [23:0] pick_rotation();
      if ($urandom_range(0, 2) == 0) return 24'($urandom());
      return 24'($signed($urandom_range(0, 46080)) - 23040);
   endfunction

   // parent for bone idx: a written lower bone, a root, or a bad link
   function automatic logic signed [6:0] pick_parent(input int idx);
      int r, p;
      r = $urandom_range(0, 99);
      if (r < 15 || idx == 0) return -7'sd1;
      if (r < 28) return 7'($urandom_range(idx, 63));
      for (int k = 0; k < 8; k++) begin
         p = $urandom_range(0, idx - 1);
         if (written[p]) return 7'(p);
      end
      return -7'sd1;
   endfunction

   initial begin
      int len, sent, base, idx;
      for (int i = 0; i < 64; i++) written[i] = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: roots at rotation and scale extremes, chains, bad links, saturation
      send_bone(6'd0, -7'sd1, 32'h0, 32'h0, 24'd0, 24'h010000, 24'h010000);
      send_bone(6'd1, 7'sd0, 32'h00010000, 32'hFFFF0000, 24'd5760, 24'h010000, 24'h010000);
      send_bone(6'd2, 7'sd1, 32'h7FFFFFFF, 32'h80000000, 24'h800000, 24'h7FFFFF, 24'h800000);
      send_bone(6'd3, -7'sd1, 32'h80000000, 32'h7FFFFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
      send_bone(6'd4, 7'sd3, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'd11520, 24'h7FFFFF, 24'h7FFFFF);
      send_bone(6'd5, 7'sd4, 32'h80000000, 32'h80000000, -24'sd11520, 24'h800000, 24'h7FFFFF);
      send_bone(6'd6, 7'sd6, 32'h12345678, 32'h9ABCDEF0, 24'd5761, 24'h020000, 24'h008000);
      send_bone(6'd7, 7'sd63, 32'h0, 32'h0, -24'sd5761, 24'h010000, 24'hFF0000);
      send_bone(6'd8, 7'sd5, 32'h00010000, 32'h00010000, -24'sd5760, 24'h000000, 24'hFFFFFF);
      send_bone(6'd9, 7'sd8, 32'h0, 32'h0, 24'd23040, 24'h010000, 24'h010000);
      send_bone(6'd3, 7'sd1, 32'h00050000, 32'h0, 24'd100, 24'h010000, 24'h010000);
      send_bone(6'd63, 7'sd2, 32'h0, 32'h0, 24'd0, 24'h010000, 24'h010000);
      send_bone(6'd63, 7'sd9, 32'hFFFFFFFF, 32'h00000001, -24'sd23040, 24'h0, 24'h0);
      send_bone(6'd10, 7'sd9, 32'h00020000, 32'h0, 24'd3, 24'h7FFFFF, 24'h7FFFFF);
      send_bone(6'd11, 7'sd10, 32'h40000000, 32'hC0000000, 24'd2880, 24'h7FFFFF, 24'h800000);

      // random skeletons: bones in index order, mostly small, a few full size
      sent = 0;
      while (sent < RANDOM_BONES) begin
         if ($urandom_range(0, 5) == 0) quiet = ~quiet;
         len = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 12);
         base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : 0;
         for (int k = 0; k < len && sent < RANDOM_BONES; k++) begin
            idx = (base + k) % 64;
            send_bone(6'(idx), pick_parent(idx), pick_offset(), pick_offset(),
                      pick_rotation(), pick_scale(), pick_scale());
            sent++;
         end
      end
      quiet = 1'b0;
      @(posedge clock);
      req_tvalid <= 1'b0;

      while (poses_pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("bones sent: %0d roots, %0d children, %0d bad parent links",
               roots, children, bad_links);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* bone_hierarchy_world_pose_top.f */
hdl/bhwp_pkg.sv
hdl/bhwp_front.sv
hdl/bhwp_fifo.sv
hdl/bhwp_back.sv
hdl/bone_hierarchy_world_pose_top.sv
hdl/bhwp_checker.sv
dv/bhwp_checker.sv
dv/testbench.sv
